>>> sv/assert_macros.svh
// Assertion macros shared by the tracker RTL.
// Needs nothing else; included by the files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at each rising edge, off while reset is low.
`define BPT_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Same check, also active during reset.
`define BPT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> sv/bpt_pkg.sv
// Shared constants and controller/datapath interface types for the tracker.
// Depends on nothing.
`timescale 1ns / 1ps

package bpt_pkg;

    localparam int HISTORY_DEPTH = 2048;
    localparam int ADDR_W        = $clog2(HISTORY_DEPTH);
    localparam int PHASE_COUNT   = 10;
    localparam int PH_W          = 4;
    localparam int DIV_W         = 32 + $clog2(PHASE_COUNT + 1);
    localparam int CNT_W         = $clog2(DIV_W);

    localparam logic [2:0] REG_ALPHA   = 3'd0;
    localparam logic [2:0] REG_PLANNED = 3'd1;
    localparam logic [2:0] REG_INITIAL = 3'd2;
    localparam logic [2:0] REG_SHIFT   = 3'd3;

    localparam logic [15:0] ALPHA_RST   = 16'd6554;
    localparam logic [15:0] PLANNED_RST = 16'd4000;
    localparam logic [15:0] INITIAL_RST = 16'd4000;

    localparam logic [1:0] CAUSE_NONE    = 2'd0;
    localparam logic [1:0] CAUSE_TIMEOUT = 2'd1;
    localparam logic [1:0] CAUSE_BAND    = 2'd2;
    localparam logic [1:0] CAUSE_CYCLE   = 2'd3;

    typedef struct packed {
        logic cap;
        logic mul1;
        logic mul2;
        logic filt;
        logic turn;
        logic peak;
        logic div_init;
        logic div_step;
        logic phase;
        logic band_rd;
        logic band;
        logic out_load;
    } bpt_cmd_t;

    typedef struct packed {
        logic active;
        logic div_done;
    } bpt_status_t;

endpackage

>>> sv/breathing_phase_tracker_unit.sv
// Top level of the breathing phase tracker: controller plus datapath.
// Depends on bpt_pkg, bpt_ctrl and bpt_datapath.
//
//   channel  dir  transaction when       payload
//   s_       in   s_tvalid & s_tready    sample_time, raw_amplitude
//   m_       out  m_tvalid & m_tready    smoothed, phase, active, new_peak, cause
//   cfg_     in   cfg_wr_en              register index and value
//
// An item runs the filter, turning point, peak and output steps; when recognition is active
// it also runs the restoring phase divider, which gives one quotient bit per cycle, and the band check.
// One item is in work at a time; the result register lets the next item enter
// while a result still waits. The history memory needs no clearing after reset.
// A stalled output holds the controller in its output step until taken.
`timescale 1ns / 1ps

module breathing_phase_tracker_unit
    import bpt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,     // sample_time[31:0], raw_amplitude[51:32], zeros
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,     // smoothed[19:0], phase[23:20], active[24],
                                     // new_peak[25], fallback_cause[27:26], zeros
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wr_data
);

    bpt_cmd_t    cmd;
    bpt_status_t st;

    bpt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .st       (st),
        .cmd      (cmd)
    );

    bpt_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .in_time     (s_tdata[31:0]),
        .in_raw      ($signed(s_tdata[51:32])),
        .cmd         (cmd),
        .st          (st),
        .out_data    (m_tdata)
    );

endmodule

>>> sv/bpt_ctrl.sv
// Sequencer for one sample: filter, turning point, peak, and when active, phase division and band check.
// Depends on bpt_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bpt_ctrl
    import bpt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  bpt_status_t st,
    output bpt_cmd_t    cmd
);

    typedef enum logic [12:0] {
        ST_IDLE   = 13'b0000000000001,
        ST_MUL1   = 13'b0000000000010,
        ST_MUL2   = 13'b0000000000100,
        ST_FILT   = 13'b0000000001000,
        ST_TURN   = 13'b0000000010000,
        ST_PEAK   = 13'b0000000100000,
        ST_DECIDE = 13'b0000001000000,
        ST_DIVI   = 13'b0000010000000,
        ST_DIV    = 13'b0000100000000,
        ST_PHASE  = 13'b0001000000000,
        ST_BRD    = 13'b0010000000000,
        ST_BAND   = 13'b0100000000000,
        ST_OUT    = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   load;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign load     = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);

    always_comb begin
        cmd          = '0;
        cmd.cap      = s_tready && s_tvalid;
        cmd.mul1     = (state_reg == ST_MUL1);
        cmd.mul2     = (state_reg == ST_MUL2);
        cmd.filt     = (state_reg == ST_FILT);
        cmd.turn     = (state_reg == ST_TURN);
        cmd.peak     = (state_reg == ST_PEAK);
        cmd.div_init = (state_reg == ST_DIVI);
        cmd.div_step = (state_reg == ST_DIV);
        cmd.phase    = (state_reg == ST_PHASE);
        cmd.band_rd  = (state_reg == ST_BRD);
        cmd.band     = (state_reg == ST_BAND);
        cmd.out_load = load;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_tvalid) state_next = ST_MUL1;
            ST_MUL1:   state_next = ST_MUL2;
            ST_MUL2:   state_next = ST_FILT;
            ST_FILT:   state_next = ST_TURN;
            ST_TURN:   state_next = ST_PEAK;
            ST_PEAK:   state_next = ST_DECIDE;
            ST_DECIDE: state_next = st.active ? ST_DIVI : ST_OUT;
            ST_DIVI:   state_next = ST_DIV;
            ST_DIV:    if (st.div_done) state_next = ST_PHASE;
            ST_PHASE:  state_next = ST_BRD;
            ST_BRD:    state_next = ST_BAND;
            ST_BAND:   state_next = ST_OUT;
            ST_OUT:    if (load) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    `BPT_ASSERT(a_one_item, aclk, aresetn, (s_tvalid && s_tready) |=> !s_tready, "second item taken during work")
    `BPT_ASSERT(a_out_src, aclk, aresetn, $rose(m_tvalid) |-> $past(state_reg == ST_OUT), "result shown outside output step")
    `BPT_ASSERT(a_div_hold, aclk, aresetn, (state_reg == ST_DIV && !st.div_done) |=> (state_reg == ST_DIV), "divider left early")

endmodule

>>> sv/bpt_datapath.sv
// Datapath: configuration, filter, peak tracking, serial phase divider, history memory.
// Depends on bpt_pkg; sequenced by bpt_ctrl.
`timescale 1ns / 1ps

module bpt_datapath
    import bpt_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_wr_data,
    input  logic [31:0]        in_time,
    input  logic signed [19:0] in_raw,
    input  bpt_cmd_t           cmd,
    output bpt_status_t        st,
    output logic [31:0]        out_data
);

    logic [15:0] alpha_reg, planned_reg;
    logic [12:0] fshift_reg;

    logic [31:0]        t_in_reg;
    logic signed [19:0] raw_reg;
    logic signed [44:0] m1_reg;
    logic signed [45:0] m2_reg;
    logic signed [27:0] f_reg;
    logic signed [19:0] amp_reg;
    logic signed [19:0] h0_reg, h1_reg, h2_reg;
    logic [31:0] rt0_reg, rt1_reg, rt2_reg;
    logic [31:0] sc_reg, newest_reg, older_reg, cpt_reg, npt_reg, cd_reg, prev_reg;
    logic        mwl_reg, active_reg, peak_reg;
    logic signed [19:0] min_reg, pamp_reg;
    logic [19:0] tol_reg;
    logic [PH_W-1:0] held_reg;
    logic [1:0]  ps_reg, cause_reg;

    logic [DIV_W-1:0] num_reg, q_reg;
    logic [31:0]      rem_reg;
    logic [CNT_W-1:0] cnt_reg;

    logic signed [19:0] mem [HISTORY_DEPTH];
    logic signed [19:0] hist_q;

    logic [19:0]     o_amp;
    logic [PH_W-1:0] o_phase;
    logic            o_act, o_peak;
    logic [1:0]      o_cause;

    // filter arithmetic
    logic signed [27:0] x_w;
    logic signed [17:0] inv_w;
    logic signed [46:0] sum_w;
    logic signed [28:0] fr_w;
    logic signed [19:0] amp_w;
    assign x_w   = {raw_reg, 8'b0};
    assign inv_w = $signed(18'h10000 - {2'b0, alpha_reg});
    assign sum_w = 47'(m1_reg) + 47'(m2_reg) + 47'sd32768;
    assign fr_w  = 29'(f_reg) + 29'sd128;
    assign amp_w = fr_w[27:8];

    // turning point
    logic signed [20:0] dr_w, ds_w;
    logic [20:0]        rise_w, swing_w;
    logic               is_min_w, is_max_w, sig_w;
    assign dr_w     = 21'(h1_reg) - 21'(min_reg);
    assign ds_w     = 21'(min_reg) - 21'(pamp_reg);
    assign rise_w   = dr_w[20] ? 21'(-dr_w) : 21'(dr_w);
    assign swing_w  = ds_w[20] ? 21'(-ds_w) : 21'(ds_w);
    assign is_min_w = (h1_reg < h0_reg) && (h1_reg < amp_w);
    assign is_max_w = (h1_reg > h0_reg) && (h1_reg > amp_w);
    assign sig_w    = (25'(rise_w) * 25'd10) > (25'(swing_w) * 25'd3);

    // peak: cycle measure and check
    logic signed [20:0] dt_w;
    logic [20:0]        tolv_w;
    logic [31:0]        d_w, tc_w;
    logic               fail_w;
    assign dt_w   = 21'(h2_reg) - 21'(min_reg);
    assign tolv_w = dt_w[20] ? 21'(-dt_w) : 21'(dt_w);
    assign d_w    = rt2_reg - npt_reg;
    assign tc_w   = d_w[31] ? (32'd0 - d_w) : d_w;
    assign fail_w = ({tc_w, 1'b0} < {17'd0, planned_reg})
                 || ({tc_w, 2'b00} < (34'(cd_reg) * 34'd3))
                 || ({1'b0, tc_w, 2'b00} > (35'(cd_reg) * 35'd5));

    // divider step
    logic [32:0] remsh_w;
    logic        qbit_w;
    assign remsh_w = {rem_reg, num_reg[DIV_W-1]};
    assign qbit_w  = (remsh_w >= {1'b0, cd_reg});

    // phase from quotient
    logic [PH_W:0] qs_w;
    assign qs_w = q_reg[PH_W:0];

    // band
    logic [31:0]        ref_w;
    logic signed [20:0] dv_w;
    logic [20:0]        dev_w;
    assign ref_w = older_reg + sc_reg - newest_reg;
    assign dv_w  = 21'(amp_reg) - 21'(hist_q);
    assign dev_w = dv_w[20] ? 21'(-dv_w) : 21'(dv_w);

    assign st.active   = active_reg;
    assign st.div_done = (cnt_reg == CNT_W'(DIV_W - 1));

    always_ff @(posedge aclk) begin
        if (cmd.turn) begin
            mem[sc_reg[ADDR_W-1:0]] <= amp_w;
        end
        if (cmd.band_rd) begin
            hist_q <= mem[ref_w[ADDR_W-1:0]];
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.cap) begin
            t_in_reg <= in_time;
            raw_reg  <= in_raw;
        end
        if (cmd.mul1) m1_reg <= $signed({1'b0, alpha_reg}) * x_w;
        if (cmd.mul2) m2_reg <= inv_w * f_reg;
        if (cmd.turn) amp_reg <= amp_w;
        if (cmd.div_init) begin
            num_reg <= DIV_W'(t_in_reg - cpt_reg) * DIV_W'(PHASE_COUNT);
            rem_reg <= '0;
            q_reg   <= '0;
            cnt_reg <= '0;
        end
        if (cmd.div_step) begin
            rem_reg <= qbit_w ? 32'(remsh_w - {1'b0, cd_reg}) : remsh_w[31:0];
            num_reg <= {num_reg[DIV_W-2:0], 1'b0};
            q_reg   <= {q_reg[DIV_W-2:0], qbit_w};
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
        if (cmd.out_load) begin
            o_amp   <= amp_reg;
            o_phase <= held_reg;
            o_act   <= active_reg;
            o_peak  <= peak_reg;
            o_cause <= cause_reg;
        end
    end

    // tracker state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_reg   <= ALPHA_RST;
            planned_reg <= PLANNED_RST;
            fshift_reg  <= '0;
            f_reg       <= '0;
            h0_reg      <= '0;
            h1_reg      <= '0;
            h2_reg      <= '0;
            rt0_reg     <= '0;
            rt1_reg     <= '0;
            rt2_reg     <= '0;
            sc_reg      <= '0;
            newest_reg  <= '0;
            older_reg   <= '0;
            cpt_reg     <= '0;
            npt_reg     <= '0;
            cd_reg      <= 32'(INITIAL_RST);
            prev_reg    <= 32'(INITIAL_RST);
            mwl_reg     <= 1'b1;
            min_reg     <= '0;
            pamp_reg    <= '0;
            tol_reg     <= '0;
            active_reg  <= 1'b0;
            held_reg    <= '0;
            ps_reg      <= '0;
            peak_reg    <= 1'b0;
            cause_reg   <= CAUSE_NONE;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_ALPHA:   alpha_reg   <= cfg_wr_data;
                    REG_PLANNED: planned_reg <= cfg_wr_data;
                    REG_INITIAL: begin
                        if (ps_reg < 2'd2) begin
                            cd_reg   <= 32'(cfg_wr_data);
                            prev_reg <= 32'(cfg_wr_data);
                        end
                    end
                    REG_SHIFT:   fshift_reg  <= cfg_wr_data[12:0];
                    default: ;
                endcase
            end
            if (cmd.cap) begin
                peak_reg  <= 1'b0;
                cause_reg <= CAUSE_NONE;
            end
            if (cmd.filt) begin
                f_reg <= (sc_reg == 32'd0) ? x_w : sum_w[43:16];
            end
            if (cmd.turn) begin
                sc_reg  <= sc_reg + 32'd1;
                h0_reg  <= amp_w;
                h1_reg  <= h0_reg;
                h2_reg  <= h1_reg;
                rt0_reg <= t_in_reg;
                rt1_reg <= rt0_reg;
                rt2_reg <= rt1_reg;
                if (sc_reg >= 32'd2) begin
                    if (mwl_reg && is_min_w) begin
                        mwl_reg <= 1'b0;
                        min_reg <= h1_reg;
                    end else if (!mwl_reg && is_max_w) begin
                        mwl_reg  <= 1'b1;
                        peak_reg <= sig_w;
                    end
                end
            end
            if (cmd.peak && peak_reg) begin
                older_reg  <= newest_reg;
                newest_reg <= sc_reg - 32'd3;
                npt_reg    <= rt2_reg;
                pamp_reg   <= h2_reg;
                tol_reg    <= tolv_w[19:0];
                if (ps_reg != 2'd0) begin
                    prev_reg <= cd_reg;
                    cd_reg   <= tc_w;
                    if (fail_w) begin
                        active_reg <= 1'b0;
                        held_reg   <= '0;
                        cause_reg  <= CAUSE_CYCLE;
                    end else begin
                        active_reg <= 1'b1;
                        cpt_reg    <= rt2_reg - 32'(fshift_reg);
                    end
                end
                if (ps_reg < 2'd2) ps_reg <= ps_reg + 2'd1;
            end
            if (cmd.phase) begin
                if (cd_reg == 32'd0 || q_reg >= DIV_W'(PHASE_COUNT + 3)) begin
                    held_reg   <= '0;
                    active_reg <= 1'b0;
                    cause_reg  <= CAUSE_TIMEOUT;
                end else if (q_reg >= DIV_W'(PHASE_COUNT)) begin
                    held_reg <= PH_W'(qs_w + (PH_W + 1)'(1) - (PH_W + 1)'(PHASE_COUNT));
                end else begin
                    held_reg <= PH_W'(qs_w + (PH_W + 1)'(1));
                end
            end
            if (cmd.band && ((23'(dev_w) << 2) > 23'(tol_reg))) begin
                held_reg   <= '0;
                active_reg <= 1'b0;
                cause_reg  <= CAUSE_BAND;
            end
        end
    end

    assign out_data = {4'b0, o_cause, o_peak, o_act, o_phase, o_amp};

endmodule
